// ===== rtl/core/rhd_pkg.sv =====
// Shared types and constants for the RTP to Annex-B H.264 depacketizer.
// No dependencies; used by rhd_parser, rhd_emitter and the top level.
package rhd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PT_W    = 7;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned NRI_W   = 3;
  localparam int unsigned NTYPE_W = 5;
  localparam int unsigned IDX_W   = 3;

  // RTP header length and saturation point of the byte position
  localparam logic [POS_W-1:0] HDR_LEN = 4'd12;
  localparam logic [POS_W-1:0] POS_SAT = 4'd14;

  // NAL unit types
  localparam logic [NTYPE_W-1:0] TYPE_SINGLE_FIRST = 5'd1;
  localparam logic [NTYPE_W-1:0] TYPE_AGG_FIRST    = 5'd24;
  localparam logic [NTYPE_W-1:0] TYPE_FU_A         = 5'd28;

  localparam logic [PT_W-1:0] VPT_RESET = 7'd96;

  // packet handling modes
  localparam logic [MODE_W-1:0] MODE_DROP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FUA    = 2'd2;

  // start code 00 00 00 01: three zero bytes then the final one
  localparam logic [IDX_W-1:0]  SC_LAST_IDX = 3'd3;
  localparam logic [IDX_W-1:0]  BYTE_IDX    = 3'd4;
  localparam logic [BYTE_W-1:0] SC_LAST_VAL = 8'h01;

  // result set caused by one packet byte
  typedef struct packed {
    logic              sc;       // start code goes out first
    logic              byte_en;  // a stream byte goes out
    logic [BYTE_W-1:0] data;
    logic              fe;       // frame ends on the last result
  } desc_t;

endpackage

// ===== rtl/core/rhd_parser.sv =====
// Packet byte parser: tracks header position, marker, payload type and
// NAL/FU-A mode, and turns each byte into a result descriptor. Uses rhd_pkg.
module rhd_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [rhd_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_last_byte,
  input  logic [rhd_pkg::PT_W-1:0]    video_pt,
  output rhd_pkg::desc_t              desc,
  output logic                        desc_vld
);

  logic [rhd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                       marker_r, marker_nxt;
  logic                       acc_r, acc_nxt;
  logic [rhd_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [rhd_pkg::NRI_W-1:0]  fnp_r, fnp_nxt;
  logic                       pend_r, pend_nxt;

  logic                         emit;
  logic                         ends;
  logic [rhd_pkg::BYTE_W-1:0]   emit_val;
  logic [rhd_pkg::NTYPE_W-1:0]  ntype;

  assign ntype = in_byte[rhd_pkg::NTYPE_W-1:0];

  always_comb begin
    pos_nxt    = pos_r;
    marker_nxt = marker_r;
    acc_nxt    = acc_r;
    mode_nxt   = mode_r;
    fnp_nxt    = fnp_r;
    emit       = 1'b0;
    ends       = 1'b0;
    emit_val   = in_byte;

    if (pos_r == '0) begin
      mode_nxt = rhd_pkg::MODE_DROP;
    end else if (pos_r == 4'd1) begin
      marker_nxt = in_byte[7];
      acc_nxt    = (in_byte[6:0] == video_pt);
    end else if (pos_r == rhd_pkg::HDR_LEN) begin
      mode_nxt = rhd_pkg::MODE_DROP;
      if (acc_r) begin
        if (ntype >= rhd_pkg::TYPE_SINGLE_FIRST && ntype < rhd_pkg::TYPE_AGG_FIRST) begin
          mode_nxt = rhd_pkg::MODE_SINGLE;
          emit     = 1'b1;
          ends     = in_last_byte;
        end else if (ntype == rhd_pkg::TYPE_FU_A) begin
          mode_nxt = rhd_pkg::MODE_FUA;
          fnp_nxt  = in_byte[7:5];
        end
      end
    end else if (pos_r == rhd_pkg::HDR_LEN + 4'd1) begin
      if (mode_r == rhd_pkg::MODE_SINGLE) begin
        emit = 1'b1;
        ends = in_last_byte;
      end else if (mode_r == rhd_pkg::MODE_FUA) begin
        // start fragment without marker: rebuild the NAL header
        emit     = in_byte[7] && !marker_r;
        emit_val = {fnp_r, in_byte[rhd_pkg::NTYPE_W-1:0]};
        ends     = in_last_byte && marker_r;
      end
    end else if (pos_r >= rhd_pkg::POS_SAT) begin
      if (mode_r == rhd_pkg::MODE_SINGLE) begin
        emit = 1'b1;
        ends = in_last_byte;
      end else if (mode_r == rhd_pkg::MODE_FUA) begin
        emit = 1'b1;
        ends = in_last_byte && marker_r;
      end
    end

    if (ends) begin
      pend_nxt = 1'b1;
    end else if (emit) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end

    if (in_last_byte) begin
      pos_nxt  = '0;
      mode_nxt = rhd_pkg::MODE_DROP;
    end else if (pos_r < rhd_pkg::POS_SAT) begin
      pos_nxt = pos_r + 4'd1;
    end
  end

  assign desc.sc      = emit && pend_r;
  assign desc.byte_en = emit;
  assign desc.data    = emit_val;
  assign desc.fe      = ends;
  assign desc_vld     = emit || ends;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      marker_r <= 1'b0;
      acc_r    <= 1'b0;
      mode_r   <= rhd_pkg::MODE_DROP;
      fnp_r    <= '0;
      pend_r   <= 1'b1;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      marker_r <= marker_nxt;
      acc_r    <= acc_nxt;
      mode_r   <= mode_nxt;
      fnp_r    <= fnp_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

// ===== rtl/core/rhd_emitter.sv =====
// Result sequencer: holds one descriptor and sends its start code, byte
// or bare flush one result per cycle while out_ready is high. Uses rhd_pkg.
module rhd_emitter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  rhd_pkg::desc_t              desc,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rhd_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_has_byte,
  output logic                        out_frame_end
);

  rhd_pkg::desc_t             desc_r;
  logic                       vld_r;
  logic [rhd_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       in_sc;
  logic                       final_res;
  logic                       take;

  assign in_sc     = desc_r.sc && (idx_r <= rhd_pkg::SC_LAST_IDX);
  assign final_res = desc_r.sc ? (idx_r == rhd_pkg::BYTE_IDX) : 1'b1;
  assign take      = vld_r && out_ready;
  assign free      = !vld_r || (take && final_res);
  assign idx_nxt   = idx_r + 3'd1;

  always_comb begin
    if (in_sc) begin
      out_byte      = (idx_r == rhd_pkg::SC_LAST_IDX) ? rhd_pkg::SC_LAST_VAL : '0;
      out_has_byte  = 1'b1;
      out_frame_end = 1'b0;
    end else begin
      out_byte      = desc_r.byte_en ? desc_r.data : '0;
      out_has_byte  = desc_r.byte_en;
      out_frame_end = desc_r.fe;
    end
  end

  assign out_valid = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (take) begin
      if (final_res) begin
        vld_r <= 1'b0;
      end
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc;
    end
  end

endmodule

// ===== rtl/core/rtp_h264_depacketizer_unit.sv =====
// Top level of the RTP to Annex-B H.264 depacketizer.
// Instantiates rhd_parser and rhd_emitter; uses rhd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one RTP packet byte per request,
//   in_last_byte marks the final byte. A fixed 12-byte RTP header is
//   assumed; header byte 1 gives marker and payload type.
//   Output channel (out_valid/out_ready): one Annex-B stream byte per
//   request, or a bare frame-end flush (out_has_byte low).
//   Config channel (cfg_valid/cfg_ready): writes the accepted video
//   payload type; always ready, write only while idle.
// A result is registered and appears in the cycle after the byte that causes it.
// Throughput: one input byte per cycle while each byte yields at most one
//   result and out_ready is high; a byte that needs the 00 00 00 01 start
//   code yields five results, and the result register then holds the input
//   off until they have left. The next byte is taken in the cycle in which
//   the last result of the previous one leaves.
// Reset (rst_n low, synchronous): position and mode are cleared, the output
//   register is emptied, a start code is pending, payload type returns to 96.
// Receiver stall: the current result holds; in_ready drops until the last
//   result of the held request is taken.
module rtp_h264_depacketizer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // packet byte input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rhd_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_last_byte,
  // stream output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rhd_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_has_byte,
  output logic                        out_frame_end,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rhd_pkg::PT_W-1:0]    cfg_video_payload_type
);

  logic [rhd_pkg::PT_W-1:0] vpt_r;
  logic                     accept;
  logic                     emit_free;
  rhd_pkg::desc_t           desc;
  logic                     desc_vld;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpt_r <= rhd_pkg::VPT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vpt_r <= cfg_video_payload_type;
    end
  end

  // a new byte goes in whenever the result register is empty or its last
  // result leaves this cycle
  assign in_ready = emit_free;
  assign accept   = in_valid && in_ready;

  rhd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .video_pt     (vpt_r),
    .desc         (desc),
    .desc_vld     (desc_vld)
  );

  // bytes that cause no result never occupy the result register
  rhd_emitter u_emitter (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (accept && desc_vld),
    .desc          (desc),
    .free          (emit_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_has_byte  (out_has_byte),
    .out_frame_end (out_frame_end)
  );

endmodule
